@@ sv/ptzd_pkg.sv @@
package ptzd_pkg;

  localparam int WindowLen       = 6;
  localparam int QueueDepth      = 2;
  localparam int DefaultMaxSpeed = 2047;

  // Result codes
  localparam logic [2:0] PanStop     = 3'd0;
  localparam logic [2:0] PanLeft     = 3'd1;
  localparam logic [2:0] PanRight    = 3'd2;
  localparam logic [2:0] PanAutoOn   = 3'd3;
  localparam logic [2:0] PanAutoOff  = 3'd4;
  localparam logic [1:0] TiltStop    = 2'd0;
  localparam logic [1:0] TiltUp      = 2'd1;
  localparam logic [1:0] TiltDown    = 2'd2;
  localparam logic [1:0] LensNone    = 2'd0;
  localparam logic [1:0] LensFirst   = 2'd1;
  localparam logic [1:0] LensSecond  = 2'd2;
  localparam logic [1:0] PowerSame   = 2'd0;
  localparam logic [1:0] PowerOn     = 2'd1;
  localparam logic [1:0] PowerOff    = 2'd2;
  localparam logic [2:0] ExtNone     = 3'd0;
  localparam logic [2:0] ExtStore    = 3'd1;
  localparam logic [2:0] ExtRecall   = 3'd2;
  localparam logic [2:0] ExtClear    = 3'd3;
  localparam logic [2:0] ExtWiperOn  = 3'd4;
  localparam logic [2:0] ExtWiperOff = 3'd5;

  // Extended function numbers carried in command byte 2 bits 5:1
  localparam logic [4:0] FnStore    = 5'd1;
  localparam logic [4:0] FnClear    = 5'd2;
  localparam logic [4:0] FnRecall   = 5'd3;
  localparam logic [4:0] FnAuxSet   = 5'd4;
  localparam logic [4:0] FnAuxClear = 5'd5;
  localparam logic [7:0] WiperAux   = 8'd1;

  // Five bytes of a frame that passed the sync and checksum tests
  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] cmd1;
    logic [7:0] cmd2;
    logic [7:0] data1;
    logic [7:0] data2;
  } frame_t;

  typedef struct packed {
    logic [7:0]  receiver_addr;
    logic        frame_kind;
    logic [2:0]  pan_action;
    logic [10:0] pan_speed;
    logic [1:0]  tilt_action;
    logic [10:0] tilt_speed;
    logic [1:0]  iris_action;
    logic [1:0]  focus_action;
    logic [1:0]  zoom_action;
    logic [1:0]  camera_power;
    logic [2:0]  ext_action;
    logic [7:0]  ext_value;
  } result_t;

endpackage

@@ sv/ptz_command_frame_decoder.sv @@
// Camera control frame decoder. Bytes of the serial command stream enter on
// the s_ side, one transfer per cycle; seven-byte frames opening with sync
// byte 0xFF whose last byte equals the 8-bit sum of bytes 1 to 5 yield one
// decoded command on the m_ side, and nothing else yields a result. A bad
// frame drops its head byte and every held byte before the next 0xFF. The
// block takes one byte every cycle while s_tready is high: sync search and
// checksum are combinational, the framer registers the window shift, and a
// good frame passes through a two-entry queue to the decoder and its output
// register. s_tready falls only while that queue is full, i.e. when results
// back up behind a stalled m_tready. Pan and tilt speeds are the data byte
// shifted left by five and capped at MAX_SPEED, then cut to 11 bits.
module ptz_command_frame_decoder #(
  parameter int MAX_SPEED = ptzd_pkg::DefaultMaxSpeed
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] receiver_addr, [10:8] pan_action, [21:11] pan_speed,
  // [23:22] tilt_action, [34:24] tilt_speed, [36:35] iris_action,
  // [38:37] focus_action, [40:39] zoom_action, [42:41] camera_power,
  // [45:43] ext_action, [53:46] ext_value, [55:54] zero
  output logic [55:0] m_tdata,
  output logic        m_tuser    // [0] frame_kind
);

  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              q_pop;
  ptzd_pkg::frame_t  frame;
  ptzd_pkg::frame_t  q_data;
  ptzd_pkg::result_t res;

  ptzd_framer u_framer (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .frame    (frame)
  );

  ptzd_queue #(
    .DEPTH (ptzd_pkg::QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (frame),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_data)
  );

  ptzd_decoder #(
    .MAX_SPEED (MAX_SPEED)
  ) u_decoder (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res      (res)
  );

  assign m_tdata = {2'b00, res.ext_value, res.ext_action, res.camera_power,
                    res.zoom_action, res.focus_action, res.iris_action,
                    res.tilt_speed, res.tilt_action, res.pan_speed,
                    res.pan_action, res.receiver_addr};
  assign m_tuser = res.frame_kind;

endmodule

@@ sv/ptzd_framer.sv @@
module ptzd_framer (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,
  input  logic            q_full,
  output logic            push,
  output ptzd_pkg::frame_t frame
);

  localparam logic [7:0] SyncByte = 8'hFF;
  localparam int FrameLen = ptzd_pkg::WindowLen + 1;

  logic [7:0] win [ptzd_pkg::WindowLen];
  logic [7:0] win_next [ptzd_pkg::WindowLen];
  logic [2:0] held;
  logic [2:0] held_next;
  logic [7:0] f [FrameLen];
  logic [7:0] sum;
  logic [2:0] k;
  logic       accept;
  logic       full;
  logic       good;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign full     = held >= 3'(ptzd_pkg::WindowLen);

  always_comb begin
    for (int i = 0; i < ptzd_pkg::WindowLen; i++) begin
      f[i] = win[i];
    end
    f[FrameLen-1] = s_tdata;
  end

  assign sum  = f[1] + f[2] + f[3] + f[4] + f[5];
  assign good = (f[0] == SyncByte) && (sum == f[FrameLen-1]);

  // First sync byte after the head; none found drops the whole frame
  always_comb begin
    k = 3'(FrameLen);
    for (int i = FrameLen - 1; i >= 1; i--) begin
      if (f[i] == SyncByte) begin
        k = 3'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < ptzd_pkg::WindowLen; i++) begin
      win_next[i] = 8'h00;
      for (int s = 1; s <= FrameLen; s++) begin
        if (k == 3'(s) && (i + s) < FrameLen) begin
          win_next[i] = f[i + s];
        end
      end
    end
    held_next = 3'(FrameLen) - k;
  end

  assign push = accept && full && good;
  assign frame = '{addr: f[1], cmd1: f[2], cmd2: f[3], data1: f[4], data2: f[5]};

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (accept) begin
      if (!full) begin
        held <= held + 3'd1;
      end else if (good) begin
        held <= '0;
      end else begin
        held <= held_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!full) begin
        win[held] <= s_tdata;
      end else if (!good) begin
        win <= win_next;
      end
    end
  end

endmodule

@@ sv/ptzd_queue.sv @@
module ptzd_queue #(
  parameter int DEPTH = ptzd_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ptzd_pkg::frame_t wr_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output ptzd_pkg::frame_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ptzd_pkg::frame_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ sv/ptzd_decoder.sv @@
module ptzd_decoder #(
  parameter int MAX_SPEED = ptzd_pkg::DefaultMaxSpeed
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  ptzd_pkg::frame_t  q_data,
  output logic              q_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output ptzd_pkg::result_t res
);

  localparam logic [15:0] MaxSpeedW = 16'(MAX_SPEED);

  ptzd_pkg::result_t dec;
  logic [4:0] fn;

  function automatic logic [10:0] scale_speed(input logic [7:0] b);
    logic [15:0] v;
    v = {3'b000, b, 5'b00000};
    if (v > MaxSpeedW) begin
      v = MaxSpeedW;
    end
    return v[10:0];
  endfunction

  assign fn = q_data.cmd2[5:1];

  always_comb begin
    dec = '0;
    dec.receiver_addr = q_data.addr;
    if (q_data.cmd2[0]) begin
      dec.frame_kind = 1'b1;
      case (fn)
        ptzd_pkg::FnStore: begin
          dec.ext_action = ptzd_pkg::ExtStore;
          dec.ext_value  = q_data.data2;
        end
        ptzd_pkg::FnRecall: begin
          dec.ext_action = ptzd_pkg::ExtRecall;
          dec.ext_value  = q_data.data2;
        end
        ptzd_pkg::FnClear: begin
          dec.ext_action = ptzd_pkg::ExtClear;
          dec.ext_value  = q_data.data2;
        end
        ptzd_pkg::FnAuxSet: begin
          dec.ext_action = (q_data.data2 == ptzd_pkg::WiperAux) ?
                           ptzd_pkg::ExtWiperOn : ptzd_pkg::ExtNone;
        end
        ptzd_pkg::FnAuxClear: begin
          dec.ext_action = (q_data.data2 == ptzd_pkg::WiperAux) ?
                           ptzd_pkg::ExtWiperOff : ptzd_pkg::ExtNone;
        end
        default: begin
          dec.ext_action = ptzd_pkg::ExtNone;
        end
      endcase
    end else begin
      // Right beats left, up beats down
      if (q_data.cmd2[1]) begin
        dec.pan_action = ptzd_pkg::PanRight;
        dec.pan_speed  = scale_speed(q_data.data1);
      end else if (q_data.cmd2[2]) begin
        dec.pan_action = ptzd_pkg::PanLeft;
        dec.pan_speed  = scale_speed(q_data.data1);
      end else begin
        dec.pan_action = ptzd_pkg::PanStop;
      end
      if (q_data.cmd2[3]) begin
        dec.tilt_action = ptzd_pkg::TiltUp;
        dec.tilt_speed  = scale_speed(q_data.data2);
      end else if (q_data.cmd2[4]) begin
        dec.tilt_action = ptzd_pkg::TiltDown;
        dec.tilt_speed  = scale_speed(q_data.data2);
      end else begin
        dec.tilt_action = ptzd_pkg::TiltStop;
      end
      if (q_data.cmd1[1]) begin
        dec.iris_action = ptzd_pkg::LensFirst;
      end else if (q_data.cmd1[2]) begin
        dec.iris_action = ptzd_pkg::LensSecond;
      end else begin
        dec.iris_action = ptzd_pkg::LensNone;
      end
      if (q_data.cmd1[0]) begin
        dec.focus_action = ptzd_pkg::LensFirst;
      end else if (q_data.cmd2[7]) begin
        dec.focus_action = ptzd_pkg::LensSecond;
      end else begin
        dec.focus_action = ptzd_pkg::LensNone;
      end
      if (q_data.cmd2[5]) begin
        dec.zoom_action = ptzd_pkg::LensFirst;
      end else if (q_data.cmd2[6]) begin
        dec.zoom_action = ptzd_pkg::LensSecond;
      end else begin
        dec.zoom_action = ptzd_pkg::LensNone;
      end
      if (q_data.cmd1[3]) begin
        dec.camera_power = q_data.cmd1[7] ? ptzd_pkg::PowerOn : ptzd_pkg::PowerOff;
      end else begin
        dec.camera_power = ptzd_pkg::PowerSame;
      end
      // Auto pan overrides the direction bits
      if (q_data.cmd1[4]) begin
        dec.pan_action = q_data.cmd1[7] ? ptzd_pkg::PanAutoOn : ptzd_pkg::PanAutoOff;
        dec.pan_speed  = '0;
      end
    end
  end

  assign q_pop = !q_empty && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res <= dec;
    end
  end

endmodule

@@ test/ptz_command_frame_decoder_checker.sv @@
`timescale 1ns / 1ps

module ptz_command_frame_decoder_checker #(
  parameter int MAX_SPEED = ptzd_pkg::DefaultMaxSpeed
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  input  logic        m_tuser,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);

  localparam logic [7:0] SyncByte = 8'hFF;
  localparam int         FrameLen = 7;

  logic [7:0]        window_bytes [ptzd_pkg::WindowLen];
  int                window_count;
  ptzd_pkg::result_t expected_cmds [$];

  function automatic logic [10:0] scale_speed(input logic [7:0] b);
    int unsigned v;
    v = 32'({b, 5'b0});
    if (v > MAX_SPEED) v = MAX_SPEED;
    return v[10:0];
  endfunction

  function automatic ptzd_pkg::result_t decode_command(input ptzd_pkg::frame_t fr);
    ptzd_pkg::result_t r;
    logic [4:0]        fn;
    r = '0;
    r.receiver_addr = fr.addr;
    if (fr.cmd2[0]) begin
      fn = fr.cmd2[5:1];
      r.frame_kind = 1'b1;
      if (fn == ptzd_pkg::FnStore) begin
        r.ext_action = ptzd_pkg::ExtStore;
        r.ext_value  = fr.data2;
      end else if (fn == ptzd_pkg::FnRecall) begin
        r.ext_action = ptzd_pkg::ExtRecall;
        r.ext_value  = fr.data2;
      end else if (fn == ptzd_pkg::FnClear) begin
        r.ext_action = ptzd_pkg::ExtClear;
        r.ext_value  = fr.data2;
      end else if (fn == ptzd_pkg::FnAuxSet && fr.data2 == ptzd_pkg::WiperAux) begin
        r.ext_action = ptzd_pkg::ExtWiperOn;
      end else if (fn == ptzd_pkg::FnAuxClear && fr.data2 == ptzd_pkg::WiperAux) begin
        r.ext_action = ptzd_pkg::ExtWiperOff;
      end
      return r;
    end
    if (fr.cmd2[1]) begin
      r.pan_action = ptzd_pkg::PanRight;
      r.pan_speed  = scale_speed(fr.data1);
    end else if (fr.cmd2[2]) begin
      r.pan_action = ptzd_pkg::PanLeft;
      r.pan_speed  = scale_speed(fr.data1);
    end
    if (fr.cmd2[3]) begin
      r.tilt_action = ptzd_pkg::TiltUp;
      r.tilt_speed  = scale_speed(fr.data2);
    end else if (fr.cmd2[4]) begin
      r.tilt_action = ptzd_pkg::TiltDown;
      r.tilt_speed  = scale_speed(fr.data2);
    end
    if (fr.cmd1[1]) r.iris_action = ptzd_pkg::LensFirst;
    else if (fr.cmd1[2]) r.iris_action = ptzd_pkg::LensSecond;
    if (fr.cmd1[0]) r.focus_action = ptzd_pkg::LensFirst;
    else if (fr.cmd2[7]) r.focus_action = ptzd_pkg::LensSecond;
    if (fr.cmd2[5]) r.zoom_action = ptzd_pkg::LensFirst;
    else if (fr.cmd2[6]) r.zoom_action = ptzd_pkg::LensSecond;
    if (fr.cmd1[3]) r.camera_power = fr.cmd1[7] ? ptzd_pkg::PowerOn : ptzd_pkg::PowerOff;
    // auto/manual pan overrides any direction bits
    if (fr.cmd1[4]) begin
      r.pan_action = fr.cmd1[7] ? ptzd_pkg::PanAutoOn : ptzd_pkg::PanAutoOff;
      r.pan_speed  = '0;
    end
    return r;
  endfunction

  // Shift one stream byte into the window; returns 1 with a decoded command
  // when the byte completes a good frame.
  function automatic bit absorb_byte(input logic [7:0] b, output ptzd_pkg::result_t r);
    logic [7:0]       f [FrameLen];
    logic [7:0]       sum;
    ptzd_pkg::frame_t fr;
    int               n;
    int               k;
    r = '0;
    n = (window_count > ptzd_pkg::WindowLen) ? ptzd_pkg::WindowLen : window_count;
    for (int i = 0; i < n; i++) f[i] = window_bytes[i];
    f[n] = b;
    if (n + 1 < FrameLen) begin
      window_bytes[n] = b;
      window_count = n + 1;
      return 1'b0;
    end
    sum = f[1] + f[2] + f[3] + f[4] + f[5];
    for (int i = 0; i < ptzd_pkg::WindowLen; i++) window_bytes[i] = '0;
    if (f[0] != SyncByte || sum != f[6]) begin
      // drop the head and everything up to the next sync byte
      k = 1;
      while (k < FrameLen && f[k] != SyncByte) k++;
      for (int i = k; i < FrameLen; i++) window_bytes[i - k] = f[i];
      window_count = FrameLen - k;
      return 1'b0;
    end
    fr = {f[1], f[2], f[3], f[4], f[5]};
    r = decode_command(fr);
    window_count = 0;
    return 1'b1;
  endfunction

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
    if (exp_v != act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    ptzd_pkg::result_t exp_r;
    ptzd_pkg::result_t new_r;
    if (rst) begin
      fail_count   = 0;
      results_seen = 0;
      window_count = 0;
      for (int i = 0; i < ptzd_pkg::WindowLen; i++) window_bytes[i] = '0;
      expected_cmds.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_cmds.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected command, expected none, got m_tdata=%h m_tuser=%b",
                   $time, m_tdata, m_tuser);
        end else begin
          exp_r = expected_cmds.pop_front();
          compare_field("receiver_addr", 32'(exp_r.receiver_addr), 32'(m_tdata[7:0]));
          compare_field("frame_kind",    32'(exp_r.frame_kind),    32'(m_tuser));
          compare_field("pan_action",    32'(exp_r.pan_action),    32'(m_tdata[10:8]));
          compare_field("pan_speed",     32'(exp_r.pan_speed),     32'(m_tdata[21:11]));
          compare_field("tilt_action",   32'(exp_r.tilt_action),   32'(m_tdata[23:22]));
          compare_field("tilt_speed",    32'(exp_r.tilt_speed),    32'(m_tdata[34:24]));
          compare_field("iris_action",   32'(exp_r.iris_action),   32'(m_tdata[36:35]));
          compare_field("focus_action",  32'(exp_r.focus_action),  32'(m_tdata[38:37]));
          compare_field("zoom_action",   32'(exp_r.zoom_action),   32'(m_tdata[40:39]));
          compare_field("camera_power",  32'(exp_r.camera_power),  32'(m_tdata[42:41]));
          compare_field("ext_action",    32'(exp_r.ext_action),    32'(m_tdata[45:43]));
          compare_field("ext_value",     32'(exp_r.ext_value),     32'(m_tdata[53:46]));
          compare_field("tdata padding", 0,                        32'(m_tdata[55:54]));
        end
      end
      if (s_tvalid && s_tready) begin
        if (absorb_byte(s_tdata, new_r)) expected_cmds.push_back(new_r);
      end
    end
    pending <= expected_cmds.size();
  end

endmodule

@@ test/ptz_command_frame_decoder_tb.sv @@
`timescale 1ns / 1ps

module ptz_command_frame_decoder_tb;

  localparam logic [7:0] SyncByte   = 8'hFF;
  localparam int         CycleLimit = 200000;
  localparam int         PhaseBytes = 500;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tuser;

  int fail_count;
  int pending;
  int results_seen;
  int bytes_sent  = 0;
  int cycle_count = 0;
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;

  ptz_command_frame_decoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  ptz_command_frame_decoder_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    m_tready    <= ($urandom_range(99) >= sink_idle_pct);
  end

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // Offer one byte, optionally after an idle gap, and hold it until the transfer.
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] cmd1,
                            input logic [7:0] cmd2, input logic [7:0] data1,
                            input logic [7:0] data2, input bit corrupt);
    logic [7:0] cksum;
    cksum = addr + cmd1 + cmd2 + data1 + data2;
    if (corrupt) cksum = cksum ^ 8'($urandom_range(1, 255));
    send_byte(SyncByte);
    send_byte(addr);
    send_byte(cmd1);
    send_byte(cmd2);
    send_byte(data1);
    send_byte(data2);
    send_byte(cksum);
  endtask

  task automatic random_traffic(input int target);
    int         pick;
    int         n;
    logic [7:0] cmd2;
    logic [4:0] fn;
    while (bytes_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        if ($urandom_range(99) < 30) begin
          fn = ($urandom_range(99) < 80) ? 5'($urandom_range(1, 5)) : 5'($urandom_range(31));
          cmd2 = {2'($urandom_range(3)), fn, 1'b1};
          send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), cmd2,
                     8'($urandom_range(255)),
                     ($urandom_range(1) != 0) ? 8'd1 : 8'($urandom_range(255)), pick >= 70);
        end else begin
          cmd2 = {7'($urandom_range(127)), 1'b0};
          send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), cmd2,
                     8'($urandom_range(255)), 8'($urandom_range(255)), pick >= 70);
        end
      end else if (pick < 88) begin
        // truncated frame: the next frame has to resync past it
        send_byte(SyncByte);
        n = $urandom_range(1, 5);
        repeat (n) send_byte(8'($urandom_range(255)));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(($urandom_range(7) == 0) ? SyncByte : 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct  = 34;
    sink_idle_pct = 79;

    // all lens bits at once, full speed caps, checksum wraps
    send_frame(8'h00, 8'h07, 8'hFE, 8'hFF, 8'hFF, 1'b0);
    // left, down, close, far, out, small speeds
    send_frame(8'hFF, 8'h04, 8'hD4, 8'h01, 8'h3F, 1'b0);
    // power on with auto pan overriding a pan direction
    send_frame(8'h12, 8'h98, 8'h02, 8'h40, 8'h00, 1'b0);
    // power off with manual pan
    send_frame(8'h34, 8'h18, 8'h00, 8'h00, 8'h00, 1'b0);
    send_frame(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    // extended: store, recall, clear, wiper on/off, aux not aimed at wiper,
    // unknown function with every other bit set
    send_frame(8'h05, 8'h00, 8'h03, 8'h00, 8'h7F, 1'b0);
    send_frame(8'h06, 8'h00, 8'h07, 8'h00, 8'hFF, 1'b0);
    send_frame(8'h07, 8'h00, 8'h05, 8'h00, 8'h00, 1'b0);
    send_frame(8'h08, 8'h00, 8'h09, 8'h00, 8'h01, 1'b0);
    send_frame(8'h09, 8'h00, 8'h0B, 8'h00, 8'h01, 1'b0);
    send_frame(8'h0A, 8'h00, 8'h09, 8'h00, 8'h02, 1'b0);
    send_frame(8'h0B, 8'hFF, 8'hFF, 8'hFF, 8'h10, 1'b0);
    // bad checksum, stray head byte, then a good frame
    send_frame(8'h20, 8'h00, 8'h02, 8'h10, 8'h00, 1'b1);
    send_byte(8'h55);
    send_frame(8'h21, 8'h00, 8'h02, 8'h10, 8'h00, 1'b0);
    // bad frame with a sync byte inside: keep from there and complete it
    send_byte(SyncByte);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(SyncByte);
    send_byte(8'h03);
    send_byte(8'h04);
    send_byte(8'h05);
    send_byte(8'h10);
    send_byte(8'h22);
    send_byte(8'h3E);

    random_traffic(bytes_sent + PhaseBytes);
    src_idle_pct  = 79;
    sink_idle_pct = 34;
    random_traffic(bytes_sent + PhaseBytes);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    random_traffic(bytes_sent + PhaseBytes);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Streamed %0d bytes: directed frames, corrupt and truncated frames, noise,",
             bytes_sent);
    $display("three pacing mixes on both sides; %0d decoded commands compared.",
             results_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
